@@ rtl/core/hre_pkg.sv @@
// ============================================================================
// hre_pkg
// Shared types and constants of the PPG heart-rate estimator: register
// indexes, rate arithmetic constants and the controller/datapath command
// and status structures.
// ============================================================================
package hre_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_OFF = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_IV      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IV      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_MIN    = 3'd4;

    // Configuration reset values.
    localparam logic [20:0] RST_SATURATION  = 21'd2000000;
    localparam logic [20:0] RST_AMBIENT_OFF = 21'd100000;
    localparam logic [15:0] RST_MIN_IV      = 16'd300;
    localparam logic [15:0] RST_MAX_IV      = 16'd2000;
    localparam logic [15:0] RST_PEAK_MIN    = 16'd5;

    // Rate arithmetic: rates are unsigned with 8 fraction bits.
    localparam int RATE_W     = 24;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_STEPS  = 24;
    localparam int BPM_W      = 8;
    localparam int OUT_W      = 23;
    localparam logic [RATE_W-1:0] RATE_BASE = 24'd15360000;   // 60000 * 256
    localparam logic [RATE_W-1:0] RATE_LOW  = 24'd10240;      // 40 bpm
    localparam logic [RATE_W-1:0] RATE_HIGH = 24'd51200;      // 200 bpm
    localparam logic [7:0]        EMA_NEW   = 8'd77;
    localparam logic [7:0]        EMA_OLD   = 8'd179;

    // Multiplier operand source codes.
    localparam logic [2:0] SRC_DC  = 3'd0;
    localparam logic [2:0] SRC_RAW = 3'd1;
    localparam logic [2:0] SRC_TMP = 3'd2;
    localparam logic [2:0] SRC_LP  = 3'd3;
    localparam logic [2:0] SRC_HP  = 3'd4;

    // Coefficient select codes.
    localparam logic [2:0] COEF_DC_KEEP = 3'd0;
    localparam logic [2:0] COEF_DC_TAKE = 3'd1;
    localparam logic [2:0] COEF_HP      = 3'd2;
    localparam logic [2:0] COEF_LP_KEEP = 3'd3;
    localparam logic [2:0] COEF_LP_TAKE = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       place;
        logic       absent;
        logic       mul_en;
        logic [2:0] mul_src;
        logic [2:0] mul_coef;
        logic       mul_lo;
        logic       acc_clr;
        logic       acc_add;
        logic       dc_wr;
        logic       ac_wr;
        logic       hpx_wr;
        logic       hp_wr;
        logic       lp_wr;
        logic       peak_eval;
        logic       div_start;
        logic       div_step;
        logic       ema;
        logic       held_wr;
        logic       out_load;
    } hre_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic present;
        logic finger;
        logic div_go;
    } hre_status_t;

endpackage

@@ rtl/core/hre_if.sv @@
// ============================================================================
// hre_if
// Channel interfaces of the heart-rate estimator: sample input, result
// output and configuration write, each with valid/ready handshake.
// ============================================================================
interface hre_sample_if #(
    parameter int SAMPLE_BITS = 22
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] led_sample;
    logic signed [SAMPLE_BITS-1:0] ambient_sample;
    logic [31:0]                   now_ms;

    modport source (output valid, output led_sample, output ambient_sample,
                    output now_ms, input ready);
    modport sink   (input valid, input led_sample, input ambient_sample,
                    input now_ms, output ready);
endinterface

interface hre_result_if;
    logic                               valid;
    logic                               ready;
    logic [hre_pkg::BPM_W-1:0]          bpm;
    logic                               finger_present;
    logic signed [hre_pkg::OUT_W-1:0]   filtered_value;

    modport source (output valid, output bpm, output finger_present,
                    output filtered_value, input ready);
    modport sink   (input valid, input bpm, input finger_present,
                    input filtered_value, output ready);
endinterface

interface hre_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hre_pkg::CFG_INDEX_W-1:0]  index;
    logic [hre_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/hre_dpath.sv @@
// ============================================================================
// hre_dpath
// Datapath of the heart-rate estimator: configuration registers, filter
// state, one shared split multiplier with accumulator, peak detector,
// restoring rate divider, EMA smoother and the result register.
// ============================================================================
module hre_dpath #(
    parameter int SAMPLE_BITS = 22,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hre_pkg::hre_cmd_t                 cmd,
    output hre_pkg::hre_status_t              status,
    input  logic                              cfg_valid,
    input  logic [hre_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hre_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]     led_sample,
    input  logic signed [SAMPLE_BITS-1:0]     ambient_sample,
    input  logic [31:0]                       now_ms,
    output logic [hre_pkg::BPM_W-1:0]         bpm,
    output logic                              finger_present,
    output logic signed [hre_pkg::OUT_W-1:0]  filtered_value
);

    // Value, accumulator and multiplier widths.
    localparam int VB   = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int ACCW = VB + 2;
    localparam int HIW  = VB - FRAC_BITS;
    localparam int AW   = (HIW > FRAC_BITS) ? HIW : FRAC_BITS;
    localparam int CW   = FRAC_BITS + 1;
    localparam int PW   = AW + CW;
    localparam int TW   = VB + 1 - FRAC_BITS;

    localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;
    localparam logic signed [ACCW-1:0] VMAX = ACCW'((longint'(1) <<< (VB - 1)) - 1);
    localparam logic signed [ACCW-1:0] VMIN = -VMAX - ACCW'(1);

    // Filter coefficients rounded to FRAC_BITS fraction bits.
    localparam logic [CW-1:0] K_DC_KEEP = CW'((995 * ONE_Q + 500) / 1000);
    localparam logic [CW-1:0] K_DC_TAKE = CW'((5 * ONE_Q + 500) / 1000);
    localparam logic [CW-1:0] K_HP      = CW'((95 * ONE_Q + 50) / 100);
    localparam logic [CW-1:0] K_LP_KEEP = CW'((8 * ONE_Q + 5) / 10);
    localparam logic [CW-1:0] K_LP_TAKE = CW'((2 * ONE_Q + 5) / 10);

    function automatic logic signed [VB-1:0] sat_val(input logic signed [ACCW-1:0] x);
        logic signed [VB-1:0] r;
        if (x > VMAX)
            r = VB'(VMAX);
        else if (x < VMIN)
            r = VB'(VMIN);
        else
            r = VB'(x);
        return r;
    endfunction

    // Configuration registers.
    logic [20:0] sat_level_reg, amb_off_reg;
    logic [15:0] min_iv_reg, max_iv_reg, peak_min_reg;

    // Captured sample.
    logic signed [SAMPLE_BITS-1:0] led_reg, amb_reg;
    logic [31:0]                   now_reg;

    // Filter and peak state.
    logic                 finger_reg, peak_seen_reg;
    logic signed [VB-1:0] dc_reg, hpi_reg, hpo_reg, lp_reg, rf1_reg, rf2_reg;
    logic signed [VB-1:0] ac_reg, tmp_reg;
    logic [31:0]          last_peak_reg;

    // Multiplier and accumulator.
    logic signed [ACCW-1:0] acc_reg;
    logic [PW-1:0]          prod_reg;
    logic                   prod_neg_reg, prod_lo_reg;

    // Divider and rate state.
    localparam int DIVISOR_W_L = hre_pkg::DIVISOR_W;
    logic [DIVISOR_W_L-1:0]        rem_reg;
    logic [DIVISOR_W_L-1:0]        dvs_reg;
    logic [hre_pkg::RATE_W-1:0]    quo_reg, sm_reg;
    logic [hre_pkg::BPM_W-1:0]     held_reg;

    // Result register.
    logic [hre_pkg::BPM_W-1:0]         bpm_reg;
    logic                              fout_reg;
    logic signed [hre_pkg::OUT_W-1:0]  filt_reg;

    // Finger presence test on the captured sample.
    logic present;
    assign present = ($signed(32'(led_reg)) > $signed({11'b0, sat_level_reg})) &&
                     ($signed(32'(amb_reg)) < $signed({11'b0, amb_off_reg}));

    // Ambient sample scaled to the value format.
    logic signed [VB-1:0] raw;
    assign raw = {HIW'(amb_reg), {FRAC_BITS{1'b0}}};

    // Multiplier operand selection and magnitude split.
    logic signed [VB-1:0] mul_v;
    logic [CW-1:0]        mul_c;
    logic                 mul_neg;
    logic [VB-1:0]        mul_mag;
    logic [AW-1:0]        mul_a;
    logic [PW-1:0]        prod_c;
    always_comb
    begin
        case (cmd.mul_src)
            hre_pkg::SRC_DC:  mul_v = dc_reg;
            hre_pkg::SRC_RAW: mul_v = raw;
            hre_pkg::SRC_TMP: mul_v = tmp_reg;
            hre_pkg::SRC_LP:  mul_v = lp_reg;
            default:          mul_v = hpo_reg;
        endcase
        case (cmd.mul_coef)
            hre_pkg::COEF_DC_KEEP: mul_c = K_DC_KEEP;
            hre_pkg::COEF_DC_TAKE: mul_c = K_DC_TAKE;
            hre_pkg::COEF_HP:      mul_c = K_HP;
            hre_pkg::COEF_LP_KEEP: mul_c = K_LP_KEEP;
            default:               mul_c = K_LP_TAKE;
        endcase
        mul_neg = mul_v[VB-1];
        mul_mag = mul_neg ? VB'(-mul_v) : VB'(mul_v);
        mul_a   = cmd.mul_lo ? AW'(mul_mag[FRAC_BITS-1:0]) : AW'(mul_mag[VB-1:FRAC_BITS]);
        prod_c  = mul_a * mul_c;
    end

    // Signed partial-product term for the accumulator.
    logic [PW-1:0]          term_mag;
    logic signed [ACCW-1:0] term;
    assign term_mag = prod_lo_reg ? (prod_reg >> FRAC_BITS) : prod_reg;
    assign term     = prod_neg_reg ? -$signed(ACCW'(term_mag)) : $signed(ACCW'(term_mag));

    logic signed [VB-1:0] acc_sat;
    assign acc_sat = sat_val(acc_reg);

    // Peak detection and interval check.
    logic signed [VB-1:0] thr;
    logic [31:0]          iv;
    logic                 peak, iv_ok;
    assign thr   = VB'({peak_min_reg, {FRAC_BITS{1'b0}}});
    assign peak  = (rf1_reg > rf2_reg) && (rf1_reg > lp_reg) && (rf1_reg > thr);
    assign iv    = now_reg - last_peak_reg;
    assign iv_ok = (iv != 32'd0) && (iv >= {16'b0, min_iv_reg}) && (iv <= {16'b0, max_iv_reg});

    assign status.present = present;
    assign status.finger  = finger_reg;
    assign status.div_go  = peak && peak_seen_reg && iv_ok;

    // Divider step.
    logic [DIVISOR_W_L:0] rem_sh;
    logic                 div_ge;
    assign rem_sh = {rem_reg, quo_reg[hre_pkg::RATE_W-1]};
    assign div_ge = rem_sh >= {1'b0, dvs_reg};

    // EMA and rounding.
    logic [32:0] ema_sum;
    logic [16:0] held_round;
    assign ema_sum = 33'(hre_pkg::EMA_NEW) * 33'(quo_reg) +
                     33'(hre_pkg::EMA_OLD) * 33'(sm_reg) + 33'd128;
    assign held_round = 17'((25'(sm_reg) + 25'd128) >> 8);

    // Low-pass value truncated toward zero and saturated for the result.
    logic              lp_neg;
    logic [VB:0]       lp_mag;
    logic [TW-1:0]     lp_q;
    logic signed [31:0] lp_int;
    logic signed [hre_pkg::OUT_W-1:0] filt_c;
    always_comb
    begin
        lp_neg = lp_reg[VB-1];
        lp_mag = lp_neg ? (VB+1)'(-$signed((VB+1)'(lp_reg))) : (VB+1)'(lp_reg);
        lp_q   = TW'(lp_mag >> FRAC_BITS);
        lp_int = lp_neg ? -$signed(32'(lp_q)) : $signed(32'(lp_q));
        if (lp_int > 32'sd4194303)
            filt_c = hre_pkg::OUT_W'(32'sd4194303);
        else if (lp_int < -32'sd4194304)
            filt_c = hre_pkg::OUT_W'(-32'sd4194304);
        else
            filt_c = hre_pkg::OUT_W'(lp_int);
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_level_reg <= hre_pkg::RST_SATURATION;
            amb_off_reg   <= hre_pkg::RST_AMBIENT_OFF;
            min_iv_reg    <= hre_pkg::RST_MIN_IV;
            max_iv_reg    <= hre_pkg::RST_MAX_IV;
            peak_min_reg  <= hre_pkg::RST_PEAK_MIN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                hre_pkg::CFG_SATURATION:  sat_level_reg <= cfg_data;
                hre_pkg::CFG_AMBIENT_OFF: amb_off_reg   <= cfg_data;
                hre_pkg::CFG_MIN_IV:      min_iv_reg    <= cfg_data[15:0];
                hre_pkg::CFG_MAX_IV:      max_iv_reg    <= cfg_data[15:0];
                hre_pkg::CFG_PEAK_MIN:    peak_min_reg  <= cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    // Sample capture, multiplier pipeline and divider registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            led_reg <= led_sample;
            amb_reg <= ambient_sample;
            now_reg <= now_ms;
        end
        if (cmd.mul_en)
        begin
            prod_reg     <= prod_c;
            prod_neg_reg <= mul_neg;
            prod_lo_reg  <= cmd.mul_lo;
        end
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + term;
        if (cmd.ac_wr)
            ac_reg <= sat_val(ACCW'(raw) - ACCW'(dc_reg));
        if (cmd.hpx_wr)
            tmp_reg <= sat_val(ACCW'(hpo_reg) + ACCW'(ac_reg) - ACCW'(hpi_reg));
        if (cmd.div_start)
        begin
            dvs_reg <= iv[DIVISOR_W_L-1:0];
            quo_reg <= hre_pkg::RATE_BASE + hre_pkg::RATE_W'(iv[DIVISOR_W_L-1:1]);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? DIVISOR_W_L'(rem_sh - {1'b0, dvs_reg})
                              : DIVISOR_W_L'(rem_sh);
            quo_reg <= {quo_reg[hre_pkg::RATE_W-2:0], div_ge};
        end
        if (cmd.out_load)
        begin
            bpm_reg  <= held_reg;
            fout_reg <= finger_reg;
            filt_reg <= filt_c;
        end
    end

    // Architectural filter, peak and rate state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_reg    <= 1'b0;
            peak_seen_reg <= 1'b0;
            dc_reg        <= '0;
            hpi_reg       <= '0;
            hpo_reg       <= '0;
            lp_reg        <= '0;
            rf1_reg       <= '0;
            rf2_reg       <= '0;
            last_peak_reg <= '0;
            sm_reg        <= '0;
            held_reg      <= '0;
        end
        else if (cmd.place)
        begin
            finger_reg    <= 1'b1;
            peak_seen_reg <= 1'b0;
            dc_reg        <= raw;
            hpi_reg       <= '0;
            hpo_reg       <= '0;
            lp_reg        <= '0;
            rf1_reg       <= '0;
            rf2_reg       <= '0;
            last_peak_reg <= '0;
            sm_reg        <= '0;
            held_reg      <= '0;
        end
        else if (cmd.absent)
        begin
            finger_reg <= 1'b0;
            held_reg   <= '0;
        end
        else
        begin
            if (cmd.dc_wr)
                dc_reg <= acc_sat;
            if (cmd.hpx_wr)
                hpi_reg <= ac_reg;
            if (cmd.hp_wr)
                hpo_reg <= acc_sat;
            // The low-pass value is also the newest entry of the peak window.
            if (cmd.lp_wr)
            begin
                lp_reg  <= acc_sat;
                rf1_reg <= lp_reg;
                rf2_reg <= rf1_reg;
            end
            if (cmd.peak_eval && peak)
            begin
                last_peak_reg <= now_reg;
                peak_seen_reg <= 1'b1;
            end
            // Seed on the first rate, then smooth with outlier rejection.
            if (cmd.ema)
            begin
                if (sm_reg == '0)
                    sm_reg <= quo_reg;
                else if ((quo_reg > hre_pkg::RATE_LOW) && (quo_reg < hre_pkg::RATE_HIGH))
                    sm_reg <= hre_pkg::RATE_W'(ema_sum >> 8);
            end
            if (cmd.held_wr)
                held_reg <= (held_round > 17'd255) ? 8'd255 : held_round[7:0];
        end
    end

    assign bpm            = bpm_reg;
    assign finger_present = fout_reg;
    assign filtered_value = filt_reg;

endmodule

@@ rtl/core/hre_ctrl.sv @@
// ============================================================================
// hre_ctrl
// Controller of the heart-rate estimator: sequences the shared multiplier,
// filter updates, peak check and rate divider for one sample at a time and
// runs the input and output handshakes.
// ============================================================================
module hre_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  hre_pkg::hre_status_t  status,
    output hre_pkg::hre_cmd_t     cmd
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CHK  = 5'd1;
    localparam logic [4:0] ST_DC0  = 5'd2;
    localparam logic [4:0] ST_DC1  = 5'd3;
    localparam logic [4:0] ST_DC2  = 5'd4;
    localparam logic [4:0] ST_DC3  = 5'd5;
    localparam logic [4:0] ST_DC4  = 5'd6;
    localparam logic [4:0] ST_DCW  = 5'd7;
    localparam logic [4:0] ST_AC   = 5'd8;
    localparam logic [4:0] ST_HPX  = 5'd9;
    localparam logic [4:0] ST_HP0  = 5'd10;
    localparam logic [4:0] ST_HP1  = 5'd11;
    localparam logic [4:0] ST_HP2  = 5'd12;
    localparam logic [4:0] ST_HPW  = 5'd13;
    localparam logic [4:0] ST_LP0  = 5'd14;
    localparam logic [4:0] ST_LP1  = 5'd15;
    localparam logic [4:0] ST_LP2  = 5'd16;
    localparam logic [4:0] ST_LP3  = 5'd17;
    localparam logic [4:0] ST_LP4  = 5'd18;
    localparam logic [4:0] ST_LPW  = 5'd19;
    localparam logic [4:0] ST_PK   = 5'd20;
    localparam logic [4:0] ST_DIV  = 5'd21;
    localparam logic [4:0] ST_EMA  = 5'd22;
    localparam logic [4:0] ST_HELD = 5'd23;
    localparam logic [4:0] ST_FIN  = 5'd24;

    localparam int CNT_W = $clog2(hre_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hre_pkg::DIV_STEPS - 1);

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Next-state and command decode.
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (!status.present)
                begin
                    cmd.absent = 1'b1;
                    state_next = ST_FIN;
                end
                else if (!status.finger)
                begin
                    cmd.place  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                    state_next = ST_DC0;
            end
            // DC estimate: keep part of the old value, take part of the sample.
            ST_DC0:
            begin
                cmd.acc_clr  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_DC;
                cmd.mul_coef = hre_pkg::COEF_DC_KEEP;
                state_next   = ST_DC1;
            end
            ST_DC1:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_DC;
                cmd.mul_coef = hre_pkg::COEF_DC_KEEP;
                cmd.mul_lo   = 1'b1;
                state_next   = ST_DC2;
            end
            ST_DC2:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_RAW;
                cmd.mul_coef = hre_pkg::COEF_DC_TAKE;
                state_next   = ST_DC3;
            end
            ST_DC3:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_RAW;
                cmd.mul_coef = hre_pkg::COEF_DC_TAKE;
                cmd.mul_lo   = 1'b1;
                state_next   = ST_DC4;
            end
            ST_DC4:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DCW;
            end
            ST_DCW:
            begin
                cmd.dc_wr  = 1'b1;
                state_next = ST_AC;
            end
            ST_AC:
            begin
                cmd.ac_wr  = 1'b1;
                state_next = ST_HPX;
            end
            ST_HPX:
            begin
                cmd.hpx_wr = 1'b1;
                state_next = ST_HP0;
            end
            // High-pass gain.
            ST_HP0:
            begin
                cmd.acc_clr  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_TMP;
                cmd.mul_coef = hre_pkg::COEF_HP;
                state_next   = ST_HP1;
            end
            ST_HP1:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_TMP;
                cmd.mul_coef = hre_pkg::COEF_HP;
                cmd.mul_lo   = 1'b1;
                state_next   = ST_HP2;
            end
            ST_HP2:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_HPW;
            end
            ST_HPW:
            begin
                cmd.hp_wr  = 1'b1;
                state_next = ST_LP0;
            end
            // Low-pass filter.
            ST_LP0:
            begin
                cmd.acc_clr  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_LP;
                cmd.mul_coef = hre_pkg::COEF_LP_KEEP;
                state_next   = ST_LP1;
            end
            ST_LP1:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_LP;
                cmd.mul_coef = hre_pkg::COEF_LP_KEEP;
                cmd.mul_lo   = 1'b1;
                state_next   = ST_LP2;
            end
            ST_LP2:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_HP;
                cmd.mul_coef = hre_pkg::COEF_LP_TAKE;
                state_next   = ST_LP3;
            end
            ST_LP3:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_src  = hre_pkg::SRC_HP;
                cmd.mul_coef = hre_pkg::COEF_LP_TAKE;
                cmd.mul_lo   = 1'b1;
                state_next   = ST_LP4;
            end
            ST_LP4:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_LPW;
            end
            ST_LPW:
            begin
                cmd.lp_wr  = 1'b1;
                state_next = ST_PK;
            end
            // Peak check; an accepted interval starts the rate divider.
            ST_PK:
            begin
                cmd.peak_eval = 1'b1;
                if (status.div_go)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_FIN;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_EMA;
            end
            ST_EMA:
            begin
                cmd.ema    = 1'b1;
                state_next = ST_HELD;
            end
            ST_HELD:
            begin
                cmd.held_wr = 1'b1;
                state_next  = ST_FIN;
            end
            // Load the result once the output register is free.
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/ppg_heart_rate_estimator_top.sv @@
// ============================================================================
// ppg_heart_rate_estimator_top
// PPG heart-rate estimator: finger detection, DC removal, high-pass and
// low-pass filtering, peak detection and smoothed BPM estimation.
// ============================================================================
//
//   Channel     Role    Transaction content
//   sample_in   sink    led_sample, ambient_sample, now_ms
//   result_out  source  bpm, finger_present, filtered_value
//   cfg         sink    index, data (register write, always ready)
//
// One sample is processed at a time. Without tracking (no finger or finger
// just placed) a sample skips the filters; a tracked sample runs through
// the one shared multiplier doing ten partial products in sequence, and
// also through the 24-step restoring rate divider when a peak gives an
// accepted interval. Reset is asynchronous, active low, and restores all
// configuration and filter state. A waiting result holds the last state
// of a sample until taken; the next sample is taken meanwhile.
//
module ppg_heart_rate_estimator_top #(
    parameter int SAMPLE_BITS = 22,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    hre_sample_if.sink   sample_in,
    hre_result_if.source result_out,
    hre_cfg_if.sink      cfg
);

    hre_pkg::hre_cmd_t    cmd;
    hre_pkg::hre_status_t status;

    // Configuration writes never stall.
    assign cfg.ready = 1'b1;

    // Sequencing controller.
    hre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Filter and rate datapath.
    hre_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .led_sample     (sample_in.led_sample),
        .ambient_sample (sample_in.ambient_sample),
        .now_ms         (sample_in.now_ms),
        .bpm            (result_out.bpm),
        .finger_present (result_out.finger_present),
        .filtered_value (result_out.filtered_value)
    );

`ifndef NO_ASSERTIONS
    // After a sample transaction the input is busy and not ready.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
        else $error("sample accepted while previous sample in progress");

    // Without a finger the reported rate is zero.
    a_no_finger_no_bpm: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.finger_present) |-> (result_out.bpm == '0))
        else $error("nonzero bpm reported without finger");
`endif

endmodule
